// ===== hw/rtl/clp_pkg.sv =====
// Shared types, token codes and keyword table for the C-subset lexer.
// Depends on nothing; every lexer module imports it.
`timescale 1ns / 1ps
`default_nettype none

package clp_pkg;

    // Default configuration
    localparam int MAX_LEXEME_DEF    = 80;
    localparam int KEYWORD_CHARS_DEF = 7;
    localparam int LINE_BITS_DEF     = 24;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Fixed payload widths
    localparam int CODE_W = 6;
    localparam int LEN_OUT_W = 7;
    localparam int LINE_OUT_W = 24;
    localparam int KW_COUNT = 17;
    localparam int KW_BITS = 56;

    // Token codes
    localparam logic [CODE_W-1:0] TK_ID     = 6'd17;
    localparam logic [CODE_W-1:0] TK_NUM    = 6'd18;
    localparam logic [CODE_W-1:0] TK_ASSIGN = 6'd19;
    localparam logic [CODE_W-1:0] TK_ADD    = 6'd20;
    localparam logic [CODE_W-1:0] TK_MUL    = 6'd21;
    localparam logic [CODE_W-1:0] TK_REL    = 6'd22;
    localparam logic [CODE_W-1:0] TK_LPAREN = 6'd23;
    localparam logic [CODE_W-1:0] TK_RPAREN = 6'd24;
    localparam logic [CODE_W-1:0] TK_SEMI   = 6'd25;
    localparam logic [CODE_W-1:0] TK_LBRACE = 6'd27;
    localparam logic [CODE_W-1:0] TK_RBRACE = 6'd28;
    localparam logic [CODE_W-1:0] TK_BAND   = 6'd31;
    localparam logic [CODE_W-1:0] TK_BOR    = 6'd32;
    localparam logic [CODE_W-1:0] TK_LOGIC  = 6'd33;
    localparam logic [CODE_W-1:0] TK_QUEST  = 6'd34;
    localparam logic [CODE_W-1:0] TK_LBRACK = 6'd35;
    localparam logic [CODE_W-1:0] TK_RBRACK = 6'd36;
    localparam logic [CODE_W-1:0] TK_DOT    = 6'd37;
    localparam logic [CODE_W-1:0] TK_MINUS  = 6'd38;
    localparam logic [CODE_W-1:0] TK_COLON  = 6'd42;
    localparam logic [CODE_W-1:0] TK_NOT    = 6'd43;
    localparam logic [CODE_W-1:0] TK_DIV    = 6'd44;
    localparam logic [CODE_W-1:0] TK_END    = 6'd45;
    localparam logic [CODE_W-1:0] TK_ERR    = 6'd46;

    // Keywords, alphabetical; code = index. Text is right-justified, first
    // character in the highest non-zero byte (matches the shift-in buffer).
    localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        KW_BITS'("break"),  KW_BITS'("case"),   KW_BITS'("char"),
        KW_BITS'("default"), KW_BITS'("do"),    KW_BITS'("double"),
        KW_BITS'("else"),   KW_BITS'("float"),  KW_BITS'("for"),
        KW_BITS'("if"),     KW_BITS'("int"),    KW_BITS'("main"),
        KW_BITS'("return"), KW_BITS'("struct"), KW_BITS'("switch"),
        KW_BITS'("void"),   KW_BITS'("while")
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd5, 3'd4, 3'd4, 3'd7, 3'd2, 3'd6, 3'd4, 3'd5, 3'd3,
        3'd2, 3'd3, 3'd4, 3'd6, 3'd6, 3'd6, 3'd4, 3'd5
    };

    // Scanner states
    typedef enum logic [2:0] {
        ST_START = 3'd0,
        ST_BANG  = 3'd1,
        ST_AMP   = 3'd2,
        ST_LTGT  = 3'd3,
        ST_EQ    = 3'd4,
        ST_BAR   = 3'd5,
        ST_NUM   = 3'd6,
        ST_WORD  = 3'd7
    } clp_state_t;

    // Output phase of the back end
    typedef enum logic {
        PH_FIRST  = 1'b0,
        PH_SECOND = 1'b1
    } clp_phase_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_code;
    } clp_in_t;

    typedef struct packed {
        logic [CODE_W-1:0]     token_code;
        logic [LEN_OUT_W-1:0]  lexeme_length;
        logic [LINE_OUT_W-1:0] line_number;
        logic                  last_of_run;
    } clp_out_t;

    typedef struct packed {
        logic [CODE_W-1:0]    code;
        logic [LEN_OUT_W-1:0] len;
    } clp_tok_t;

    // One queue entry: the one or two tokens caused by one item
    typedef struct packed {
        logic                  two;
        clp_tok_t              tok0;
        clp_tok_t              tok1;
        logic [LINE_OUT_W-1:0] line;
    } clp_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/clp_front.sv =====
// Front end: scanner state machine, word buffer, keyword match, line count.
// Produces one queue entry per item that yields tokens. Uses clp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clp_front
    import clp_pkg::*;
#(
    parameter int MAX_LEXEME    = MAX_LEXEME_DEF,
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
    parameter int LINE_BITS     = LINE_BITS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire clp_in_t    in_data,
    input  wire logic       q_full,
    output logic            push,
    output clp_entry_t      push_entry
);

    localparam int LEN_W = $clog2(MAX_LEXEME + 1);
    localparam int BUF_W = 8 * KEYWORD_CHARS;

    typedef struct packed {
        logic              emit;
        logic [CODE_W-1:0] code;
        clp_state_t        nxt;
        logic              newline;
        logic              word;
    } start_t;

    function automatic start_t start_class(input logic [7:0] ch);
        start_t r;
        logic   dig;
        logic   ltr;
        r       = '0;
        r.nxt   = ST_START;
        dig     = (ch >= "0") && (ch <= "9");
        ltr     = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
        r.code  = TK_ERR;
        unique case (ch)
            "\n":     r.newline = 1'b1;
            "\t", " ": r.emit = 1'b0;
            "!":      r.nxt = ST_BANG;
            "&":      r.nxt = ST_AMP;
            "<", ">": r.nxt = ST_LTGT;
            "=":      r.nxt = ST_EQ;
            "|":      r.nxt = ST_BAR;
            "(":      begin r.emit = 1'b1; r.code = TK_LPAREN; end
            ")":      begin r.emit = 1'b1; r.code = TK_RPAREN; end
            "*":      begin r.emit = 1'b1; r.code = TK_MUL;    end
            "/":      begin r.emit = 1'b1; r.code = TK_DIV;    end
            "+":      begin r.emit = 1'b1; r.code = TK_ADD;    end
            "-":      begin r.emit = 1'b1; r.code = TK_MINUS;  end
            ".":      begin r.emit = 1'b1; r.code = TK_DOT;    end
            ":":      begin r.emit = 1'b1; r.code = TK_COLON;  end
            ";":      begin r.emit = 1'b1; r.code = TK_SEMI;   end
            "?":      begin r.emit = 1'b1; r.code = TK_QUEST;  end
            "[":      begin r.emit = 1'b1; r.code = TK_LBRACK; end
            "]":      begin r.emit = 1'b1; r.code = TK_RBRACK; end
            "{":      begin r.emit = 1'b1; r.code = TK_LBRACE; end
            "}":      begin r.emit = 1'b1; r.code = TK_RBRACE; end
            default:
            begin
                if (dig) begin
                    r.nxt  = ST_NUM;
                    r.word = 1'b1;
                end else if (ltr) begin
                    r.nxt  = ST_WORD;
                    r.word = 1'b1;
                end else begin
                    r.emit = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    clp_state_t           state_reg, state_next;
    logic [BUF_W-1:0]     buf_reg, buf_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LINE_BITS-1:0] line_reg, line_next;

    logic                 fire;
    logic                 is_end;
    logic [7:0]           ch;
    logic                 is_dig;
    logic                 is_let;
    start_t               fs;
    logic                 combo;
    logic                 grow;
    logic [CODE_W-1:0]    kw_code;
    logic                 pend_valid;
    clp_tok_t             pend_tok;
    logic [15:0]          len_wide;
    logic [31:0]          line_wide;
    logic                 a_valid;
    clp_tok_t             a_tok;
    logic                 b_valid;
    clp_tok_t             b_tok;

    assign in_ready  = !q_full;
    assign fire      = in_valid && !q_full;
    assign is_end    = in_data.req_type;
    assign ch        = in_data.char_code;
    assign is_dig    = (ch >= "0") && (ch <= "9");
    assign is_let    = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
    assign fs        = start_class(ch);
    assign len_wide  = 16'(len_reg);
    assign line_wide = 32'(line_reg);

    // Keyword match: parallel compare of the buffer against the table
    always_comb
    begin
        kw_code = TK_ID;
        for (int k = 0; k < KW_COUNT; k++) begin
            if ((buf_reg == BUF_W'(KW_TEXT[k])) && (len_reg == LEN_W'(KW_LEN[k]))) begin
                kw_code = CODE_W'(k);
            end
        end
    end

    // Does this character extend the pending token?
    always_comb
    begin
        combo = 1'b0;
        grow  = 1'b0;
        unique case (state_reg)
            ST_START:               combo = 1'b0;
            ST_BANG, ST_EQ, ST_LTGT: combo = (ch == "=");
            ST_AMP:                 combo = (ch == "&");
            ST_BAR:                 combo = (ch == "|");
            ST_NUM:                 grow  = is_dig;
            ST_WORD:                grow  = is_dig || is_let;
            default:                combo = 1'b0;
        endcase
        if (is_end) begin
            combo = 1'b0;
            grow  = 1'b0;
        end
    end

    // Token held by the scanner, flushed when the next character ends it
    always_comb
    begin
        pend_valid   = (state_reg != ST_START);
        pend_tok.len = LEN_OUT_W'(1);
        unique case (state_reg)
            ST_BANG: pend_tok.code = TK_NOT;
            ST_AMP:  pend_tok.code = TK_BAND;
            ST_LTGT: pend_tok.code = TK_REL;
            ST_EQ:   pend_tok.code = TK_ASSIGN;
            ST_BAR:  pend_tok.code = TK_BOR;
            ST_NUM:
            begin
                pend_tok.code = TK_NUM;
                pend_tok.len  = len_wide[LEN_OUT_W-1:0];
            end
            ST_WORD:
            begin
                pend_tok.code = kw_code;
                pend_tok.len  = len_wide[LEN_OUT_W-1:0];
            end
            default: pend_tok.code = TK_ERR;
        endcase
    end

    // Token outputs of this item
    always_comb
    begin
        a_valid = pend_valid;
        a_tok   = pend_tok;
        b_valid = is_end || fs.emit;
        b_tok.code = is_end ? TK_END : fs.code;
        b_tok.len  = is_end ? LEN_OUT_W'(0) : LEN_OUT_W'(1);
        if (combo) begin
            a_valid    = 1'b1;
            a_tok.code = ((state_reg == ST_AMP) || (state_reg == ST_BAR)) ? TK_LOGIC : TK_REL;
            a_tok.len  = LEN_OUT_W'(2);
            b_valid    = 1'b0;
        end else if (grow) begin
            a_valid = 1'b0;
            b_valid = 1'b0;
        end

        push            = fire && (a_valid || b_valid);
        push_entry.line = line_wide[LINE_OUT_W-1:0];
        push_entry.tok1 = b_tok;
        if (a_valid) begin
            push_entry.tok0 = a_tok;
            push_entry.two  = b_valid;
        end else begin
            push_entry.tok0 = b_tok;
            push_entry.two  = 1'b0;
        end
    end

    // Scanner next state
    always_comb
    begin
        state_next = state_reg;
        buf_next   = buf_reg;
        len_next   = len_reg;
        line_next  = line_reg;
        if (fire) begin
            if (is_end || combo) begin
                state_next = ST_START;
            end else if (grow) begin
                if (int'(len_reg) < KEYWORD_CHARS) begin
                    buf_next = {buf_reg[BUF_W-9:0], ch};
                end
                if (int'(len_reg) < MAX_LEXEME) begin
                    len_next = len_reg + 1'b1;
                end
            end else begin
                state_next = fs.nxt;
                if (fs.newline && (line_reg != {LINE_BITS{1'b1}})) begin
                    line_next = line_reg + 1'b1;
                end
                if (fs.word) begin
                    buf_next = BUF_W'(ch);
                    len_next = LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_START;
            buf_reg   <= '0;
            len_reg   <= '0;
            line_reg  <= LINE_BITS'(1);
        end else begin
            state_reg <= state_next;
            buf_reg   <= buf_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/clp_queue.sv =====
// Small register FIFO of token entries between front and back end.
// Uses clp_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module clp_queue
    import clp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire clp_entry_t  push_entry,
    output logic             full,
    output logic             not_empty,
    output clp_entry_t       head,
    input  wire logic        pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clp_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/clp_back.sv =====
// Back end: unpacks queue entries into single tokens on a registered output.
// Uses clp_pkg for entry, payload and phase types.
`timescale 1ns / 1ps
`default_nettype none

module clp_back
    import clp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire clp_entry_t  q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output clp_out_t         out_data
);

    clp_phase_t phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;
    clp_out_t   out_data_reg, out_data_next;
    logic       load;

    assign load      = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Outputs: pick the token of the current phase, pop after the last one
    always_comb
    begin
        out_data_next.line_number = q_head.line;
        unique case (phase_reg)
            PH_FIRST:
            begin
                out_data_next.token_code    = q_head.tok0.code;
                out_data_next.lexeme_length = q_head.tok0.len;
                out_data_next.last_of_run   = !q_head.two;
                q_pop                       = load && !q_head.two;
            end
            PH_SECOND:
            begin
                out_data_next.token_code    = q_head.tok1.code;
                out_data_next.lexeme_length = q_head.tok1.len;
                out_data_next.last_of_run   = 1'b1;
                q_pop                       = load;
            end
            default:
            begin
                out_data_next = '0;
                q_pop         = 1'b0;
            end
        endcase
        if (load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (load) begin
            unique case (phase_reg)
                PH_FIRST:  phase_next = q_head.two ? PH_SECOND : PH_FIRST;
                PH_SECOND: phase_next = PH_FIRST;
                default:   phase_next = PH_FIRST;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_FIRST;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/c_subset_lexer.sv =====
// Lexer top: one character item per cycle in, one token per cycle out, unless stalled.
// Path: each item's tokens go into the entry queue, then into the output register.
// Throughput: one item per cycle while the queue has room; an item yielding two
// tokens holds the output for both; the entry queue absorbs that as input flows.
// Reset: async low; scanner at start state, line count 1, queue and output empty.
// Depends on clp_pkg, clp_front, clp_queue, clp_back.
`timescale 1ns / 1ps
`default_nettype none

module c_subset_lexer
    import clp_pkg::*;
#(
    parameter int MAX_LEXEME    = MAX_LEXEME_DEF,     // lexeme length saturation
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,  // chars kept for keyword match
    parameter int LINE_BITS     = LINE_BITS_DEF,      // line counter width
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF     // entries between front and back
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire clp_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output clp_out_t      out_data
);

    // Front to queue
    logic       q_full;
    logic       q_push;
    clp_entry_t q_push_entry;

    // Queue to back
    logic       q_not_empty;
    clp_entry_t q_head;
    logic       q_pop;

    // Front end classifies each character item and runs the scanner; it
    // stalls only when the queue is full.
    clp_front #(
        .MAX_LEXEME    (MAX_LEXEME),
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .LINE_BITS     (LINE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .q_full     (q_full),
        .push       (q_push),
        .push_entry (q_push_entry)
    );

    // Each entry carries all tokens of one item, so ordering is preserved.
    clp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head),
        .pop        (q_pop)
    );

    // Back end streams tokens out through a single output register.
    clp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
